/* rtl/crm_pkg.sv */
// ---------------------------------------------------------------------------
// crm_pkg: shared definitions for the cyclic rotate-and-mask block
// Command codes, controller states, the control and status bundles that run
// between controller and datapath, and a small mask helper.
// ---------------------------------------------------------------------------
`default_nettype none

package crm_pkg;

	localparam int WORD_BITS = 64;
	localparam int LEN_W     = 15;
	localparam int CMD_W     = 2;
	localparam int IDX_W     = 8;
	localparam int SHIFT_W   = 14;

	localparam logic [LEN_W-1:0] LEN_RESET = 15'd12323;

	localparam logic [CMD_W-1:0] CMD_WR_CAND = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WR_MASK = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_PREP,
		ST_RD_B,
		ST_RD_C,
		ST_FIN,
		ST_LOAD
	} crm_state_t;

	// Source of the candidate memory address.
	typedef enum logic [1:0] {
		ASEL_IDX,
		ASEL_A,
		ASEL_B,
		ASEL_ZERO
	} crm_asel_t;

	typedef struct packed {
		logic      load_in;
		logic      eval;
		logic      prep;
		logic      cap_a;
		logic      cap_b;
		logic      fin;
		logic      load_out;
		crm_asel_t asel;
	} crm_ctl_t;

	typedef struct packed {
		logic rd_ok;
		logic out_free;
	} crm_sts_t;

	// Ones in the low k bits, or in all bits when full is set.
	function automatic logic [WORD_BITS-1:0] low_mask(input logic full, input logic [5:0] k);
		logic [WORD_BITS-1:0] m;
		m = (64'd1 << k) - 64'd1;
		return full ? '1 : m;
	endfunction

endpackage

`default_nettype wire

/* rtl/crm_ctrl.sv */
// ---------------------------------------------------------------------------
// crm_ctrl: sequencing controller
// Accepts one item at a time and steps the datapath through evaluation,
// the candidate word fetches and the hand-off to the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module crm_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire crm_pkg::crm_sts_t sts,
	output crm_pkg::crm_ctl_t      ctl
);
	import crm_pkg::*;

	crm_state_t state_q;
	crm_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				state_d = sts.rd_ok ? ST_PREP : ST_LOAD;
			end
			ST_PREP: state_d = ST_RD_B;
			ST_RD_B: state_d = ST_RD_C;
			ST_RD_C: state_d = ST_FIN;
			ST_FIN:  state_d = ST_LOAD;
			ST_LOAD: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl      = '0;
		ctl.asel = ASEL_IDX;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				ctl.load_in = in_valid;
			end
			ST_EVAL: ctl.eval = 1'b1;
			ST_PREP: begin
				ctl.prep = 1'b1;
				ctl.asel = ASEL_A;
			end
			ST_RD_B: begin
				ctl.cap_a = 1'b1;
				ctl.asel  = ASEL_B;
			end
			ST_RD_C: begin
				ctl.cap_b = 1'b1;
				ctl.asel  = ASEL_ZERO;
			end
			ST_FIN:  ctl.fin = 1'b1;
			ST_LOAD: ctl.load_out = sts.out_free;
			default: ctl = '0;
		endcase
	end

endmodule

`default_nettype wire

/* rtl/crm_datapath.sv */
// ---------------------------------------------------------------------------
// crm_datapath: storage and arithmetic of the rotate-and-mask block
// Holds the length register, both word memories, the item registers, the
// start-position arithmetic, the funnel shift with wrap, and the output
// register.
// ---------------------------------------------------------------------------
`default_nettype none

module crm_datapath #(
	parameter int MAX_WORDS = 256
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire crm_pkg::crm_ctl_t                 ctl,
	output crm_pkg::crm_sts_t                      sts,
	input  wire logic [crm_pkg::LEN_W-1:0]         cfg_len,
	input  wire logic                              cfg_we,
	input  wire logic [crm_pkg::CMD_W-1:0]         in_cmd,
	input  wire logic [crm_pkg::IDX_W-1:0]         in_idx,
	input  wire logic [crm_pkg::WORD_BITS-1:0]     in_data,
	input  wire logic [crm_pkg::SHIFT_W-1:0]       in_shift,
	input  wire logic                              out_ready,
	output logic                                   out_valid,
	output logic [crm_pkg::WORD_BITS-1:0]          out_word,
	output logic                                   out_status
);
	import crm_pkg::*;

	localparam int AW  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int XW  = (AW > IDX_W) ? AW : IDX_W;
	localparam int RW0 = $clog2(WORD_BITS * MAX_WORDS + 1);
	localparam int RW  = (RW0 > LEN_W) ? RW0 : LEN_W;

	localparam logic [RW-1:0] R_CAP   = RW'(WORD_BITS * MAX_WORDS);
	localparam logic [RW-1:0] R_RESET = (RW'(LEN_RESET) > R_CAP) ? R_CAP : RW'(LEN_RESET);
	localparam logic [XW:0]   MAXW_X  = (XW + 1)'(MAX_WORDS);
	localparam logic [RW-1:0] WB_R    = RW'(WORD_BITS);

	// Item and length registers
	logic [RW-1:0]        r_q;
	logic [CMD_W-1:0]     cmd_q;
	logic [IDX_W-1:0]     idx_q;
	logic [WORD_BITS-1:0] data_q;
	logic [SHIFT_W-1:0]   shift_q;

	// Read arithmetic
	logic [XW-1:0]        idx_x;
	logic                 wr_ok;
	logic                 rd_ok;
	logic                 is_wr;
	logic [RW-1:0]        pw;
	logic [RW-1:0]        shift_x;
	logic [RW:0]          diff;
	logic [RW-1:0]        s0_next;
	logic [RW-1:0]        n_rem;
	logic [RW-1:0]        s0_q;
	logic [RW-1:0]        m_q;
	logic [5:0]           nlo_q;
	logic [WORD_BITS-1:0] nmask_q;
	logic [WORD_BITS-1:0] vmask_q;
	logic [WORD_BITS-1:0] a_q;
	logic [WORD_BITS-1:0] b_q;
	logic [WORD_BITS-1:0] res_q;
	logic                 stat_q;
	logic [2*WORD_BITS-1:0] funnel;
	logic [WORD_BITS-1:0] cand_word;

	// Memories
	logic [RW-7:0]        s0w;
	logic [AW-1:0]        addr_idx;
	logic [AW-1:0]        addr_a;
	logic [AW-1:0]        cand_addr;
	logic                 cand_we;
	logic                 mask_we;
	logic [WORD_BITS-1:0] cand_mem [MAX_WORDS];
	logic [WORD_BITS-1:0] mask_mem [MAX_WORDS];
	logic [WORD_BITS-1:0] cand_rd;
	logic [WORD_BITS-1:0] mask_rd;

	// Output register
	logic                 out_valid_q;
	logic [WORD_BITS-1:0] out_word_q;
	logic                 out_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q <= R_RESET;
		end else if (cfg_we) begin
			r_q <= (RW'(cfg_len) > R_CAP) ? R_CAP : RW'(cfg_len);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			cmd_q   <= in_cmd;
			idx_q   <= in_idx;
			data_q  <= in_data;
			shift_q <= in_shift;
		end
	end

	assign idx_x   = XW'(idx_q);
	assign wr_ok   = {1'b0, idx_x} < MAXW_X;
	assign pw      = RW'({idx_q, 6'd0});
	assign shift_x = RW'(shift_q);
	assign is_wr   = (cmd_q == CMD_WR_CAND) || (cmd_q == CMD_WR_MASK);
	assign rd_ok   = (cmd_q == CMD_READ) && (shift_x < r_q) && (pw < r_q);

	// First source position of the word: (64 * index - shift) mod r.
	assign diff    = {1'b0, pw} - {1'b0, shift_x};
	assign s0_next = diff[RW] ? (diff[RW-1:0] + r_q) : diff[RW-1:0];
	// Source bits left before the wrap back to position zero.
	assign n_rem   = r_q - s0_q;

	always_ff @(posedge clk) begin
		if (ctl.eval) begin
			s0_q   <= s0_next;
			m_q    <= r_q - pw;
			res_q  <= '0;
			stat_q <= is_wr ? !wr_ok : !rd_ok;
		end
		if (ctl.prep) begin
			nlo_q   <= n_rem[5:0];
			nmask_q <= low_mask(n_rem >= WB_R, n_rem[5:0]);
			vmask_q <= low_mask(m_q >= WB_R, m_q[5:0]);
		end
		if (ctl.cap_a) a_q <= cand_rd;
		if (ctl.cap_b) b_q <= cand_rd;
		if (ctl.fin) res_q <= cand_word & mask_rd & vmask_q;
	end

	// Unwrapped bits come from words A and B; the wrapped tail starts at word zero,
	// which is on the read port during the final step.
	assign funnel    = {b_q, a_q} >> s0_q[5:0];
	assign cand_word = (funnel[WORD_BITS-1:0] & nmask_q) | ((cand_rd << nlo_q) & ~nmask_q);

	assign s0w      = s0_q[RW-1:6];
	assign addr_a   = s0w[AW-1:0];
	assign addr_idx = idx_x[AW-1:0];

	always_comb begin
		unique case (ctl.asel)
			ASEL_IDX:  cand_addr = addr_idx;
			ASEL_A:    cand_addr = addr_a;
			ASEL_B:    cand_addr = addr_a + AW'(1);
			ASEL_ZERO: cand_addr = '0;
			default:   cand_addr = addr_idx;
		endcase
	end

	assign cand_we = ctl.eval && (cmd_q == CMD_WR_CAND) && wr_ok;
	assign mask_we = ctl.eval && (cmd_q == CMD_WR_MASK) && wr_ok;

	always_ff @(posedge clk) begin
		if (cand_we) cand_mem[cand_addr] <= data_q;
		cand_rd <= cand_mem[cand_addr];
	end

	always_ff @(posedge clk) begin
		if (mask_we) mask_mem[addr_idx] <= data_q;
		mask_rd <= mask_mem[addr_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			out_word_q   <= res_q;
			out_status_q <= stat_q;
		end
	end

	assign sts.rd_ok    = rd_ok;
	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign out_word     = out_word_q;
	assign out_status   = out_status_q;

endmodule

`default_nettype wire

/* rtl/cyclic_rotate_and_mask.sv */
// ---------------------------------------------------------------------------
// cyclic_rotate_and_mask: rotated candidate word ANDed with a mask word
// Keeps a candidate and a mask bit vector of configurable cyclic length in
// word memories, loads words on write items and returns one rotated, masked
// word with a status bit for every item.
//
//   Channel  Dir  Handshake           Payload
//   s_*      in   s_tvalid/s_tready   tuser: cmd; tdata: word_index, data, shift
//   m_*      out  m_tvalid/m_tready   tuser: status; tdata: word
//   cfg_*    in   cfg_valid/cfg_ready cfg_data: length_bits
//
// Writes and rejected items pass through evaluation and the hand-off step
// before the next item is accepted. Reads fetch the three candidate words
// (two for the funnel shift, word zero for the wrap) one after another on the
// single port of the candidate memory.
// A finished result waits in the output register while the next item is
// accepted; a stalled output holds the controller only at its hand-off step.
// Reset clears control state and the length register; the memories come up undefined.
// ---------------------------------------------------------------------------
`default_nettype none

module cyclic_rotate_and_mask #(
	parameter int MAX_WORDS = 256
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [87:0]  s_tdata,   // word_index[7:0], data[71:8], shift[85:72], zero
	input  wire logic [1:0]   s_tuser,   // cmd[1:0]
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [63:0]       m_tdata,   // word[63:0]
	output logic [0:0]        m_tuser,   // status[0]
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [14:0]  cfg_data   // length_bits[14:0]
);
	import crm_pkg::*;

	crm_ctl_t ctl;
	crm_sts_t sts;
	logic     out_status;

	assign cfg_ready = 1'b1;

	crm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	crm_datapath #(
		.MAX_WORDS (MAX_WORDS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sts        (sts),
		.cfg_len    (cfg_data),
		.cfg_we     (cfg_valid),
		.in_cmd     (s_tuser),
		.in_idx     (s_tdata[7:0]),
		.in_data    (s_tdata[71:8]),
		.in_shift   (s_tdata[85:72]),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_word   (m_tdata),
		.out_status (out_status)
	);

	assign m_tuser[0] = out_status;

	// One item at a time: no transfer in the cycle right after one.
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken again while an item is in progress");

	// The output register is loaded only when it is empty or being drained.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_out |-> (!m_tvalid || m_tready))
		else $error("output register overwritten before transfer");

	// An error result carries a zero word.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata == 64'd0))
		else $error("error result with nonzero word");

	// The memory fetch sequence runs only for reads that passed the range checks.
	a_fetch_ok: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.prep |-> $past(ctl.eval) && $past(sts.rd_ok))
		else $error("word fetch started for a rejected item");

endmodule

`default_nettype wire
